@@ rtl/kpl_pkg.sv @@
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types, codes and the keypad decode table for the password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

    // lock modes, as shown on the result stream
    typedef enum logic [1:0] {
        MODE_ENTRY  = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_NEWPW  = 2'd2,
        MODE_LOCKED = 2'd3
    } mode_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ATTEMPTS   = 1'd0,
        CFG_MIN_NEW_LENGTH = 1'd1
    } cfg_idx_t;

    localparam int CFG_DATA_W = 4;

    // register reset values
    localparam logic [3:0] MAX_ATTEMPTS_RST   = 4'd3;
    localparam logic [3:0] MIN_NEW_LENGTH_RST = 4'd6;

    // decoded key codes above the decimal digits
    localparam logic [3:0] KEY_CLEAR = 4'd10;
    localparam logic [3:0] KEY_ENTER = 4'd11;
    localparam logic [3:0] KEY_OTHER = 4'd12;

    localparam int KEY_W      = 4;
    localparam int NIBBLES    = 8;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 48;

    // key request handed from the input register to the core
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } key_req_t;

    // one result item, mode in the lowest bits
    typedef struct packed {
        logic                   entry_matches;
        logic [4*NIBBLES-1:0]   entry_digits;
        logic [3:0]             entry_length;
        logic [3:0]             attempts_left;
        mode_t                  mode;
    } result_t;

    // 4x4 keypad position to key code
    function automatic logic [3:0] key_code(input logic [KEY_W-1:0] idx);
        logic [3:0] code;
        unique case (idx)
            4'd0:    code = 4'd7;
            4'd1:    code = 4'd8;
            4'd2:    code = 4'd9;
            4'd4:    code = 4'd4;
            4'd5:    code = 4'd5;
            4'd6:    code = 4'd6;
            4'd8:    code = 4'd1;
            4'd9:    code = 4'd2;
            4'd10:   code = 4'd3;
            4'd12:   code = KEY_CLEAR;
            4'd13:   code = 4'd0;
            4'd14:   code = KEY_ENTER;
            default: code = KEY_OTHER;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/kpl_in_stage.sv @@
// ----------------------------------------------------------------------------
// kpl_in_stage
// Input register for key requests; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module kpl_in_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kpl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [3:0] key_index
    input  logic                             advance,
    output kpl_pkg::key_req_t                req
);

    logic                        valid_reg, valid_next;
    logic [kpl_pkg::KEY_W-1:0]   key_reg;
    logic                        take;

    // free when empty or being drained this cycle
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
            key_reg <= s_axis_tdata[kpl_pkg::KEY_W-1:0];
    end

    assign req.valid = valid_reg;
    assign req.key   = key_reg;

endmodule

@@ rtl/kpl_match.sv @@
// ----------------------------------------------------------------------------
// kpl_match
// Parallel compare of an entry against the stored password, digits and length.
// ----------------------------------------------------------------------------
module kpl_match #(
    parameter int MAX_DIGITS = 8
) (
    input  logic [$clog2(MAX_DIGITS+1)-1:0]  entry_cnt,
    input  logic [MAX_DIGITS-1:0][3:0]       entry_digits,
    input  logic [$clog2(MAX_DIGITS+1)-1:0]  stored_cnt,
    input  logic [MAX_DIGITS-1:0][3:0]       stored_digits,
    output logic                             equal
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic [MAX_DIGITS-1:0] slot_ok;

    // slots at or above the length do not count
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            slot_ok[i] = (CW'(i) >= entry_cnt) || (entry_digits[i] == stored_digits[i]);
        end
    end

    assign equal = (entry_cnt == stored_cnt) && (&slot_ok);

endmodule

@@ rtl/kpl_core.sv @@
// ----------------------------------------------------------------------------
// kpl_core
// Lock state, configuration registers and the single-pass next-state logic.
// ----------------------------------------------------------------------------
module kpl_core #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [kpl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  kpl_pkg::key_req_t                 req,
    input  logic                              advance,
    output kpl_pkg::result_t                  res_next
);

    localparam int CW     = $clog2(MAX_DIGITS + 1);
    localparam int IW     = $clog2(MAX_DIGITS);
    localparam int LW     = (CW > 4) ? CW : 4;
    localparam int PACK_N = (MAX_DIGITS < kpl_pkg::NIBBLES) ? MAX_DIGITS : kpl_pkg::NIBBLES;
    localparam int STORED_RST = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;

    kpl_pkg::mode_t              mode_reg, mode_next;
    logic [3:0]                  min_len_reg;
    logic [3:0]                  att_reg, att_next;
    logic [CW-1:0]               cnt_reg, cnt_next, edit_cnt;
    logic [CW-1:0]               stored_cnt_reg, stored_cnt_next;
    logic [MAX_DIGITS-1:0][3:0]  entry_reg, entry_next;
    logic [MAX_DIGITS-1:0][3:0]  stored_reg, stored_next;
    logic [3:0]                  code;
    logic                        is_digit, is_clear, is_enter;
    logic                        edit_we, save, match_cur, match_next;
    logic [4*kpl_pkg::NIBBLES-1:0] packed_digits;

    // key decode
    assign code     = kpl_pkg::key_code(req.key);
    assign is_digit = (code <= 4'd9);
    assign is_clear = (code == kpl_pkg::KEY_CLEAR);
    assign is_enter = (code == kpl_pkg::KEY_ENTER);

    // entry edit: append while not full, delete while not empty
    assign edit_we = is_digit && (cnt_reg != CW'(MAX_DIGITS));
    always_comb
    begin
        if (edit_we)
            edit_cnt = cnt_reg + CW'(1);
        else if (is_clear && (cnt_reg != '0))
            edit_cnt = cnt_reg - CW'(1);
        else
            edit_cnt = cnt_reg;
    end

    // new password long enough to save
    assign save = is_enter && (LW'(cnt_reg) >= LW'(min_len_reg));

    // compare before the update, for the check on enter
    kpl_match #(.MAX_DIGITS(MAX_DIGITS)) u_match_cur (
        .entry_cnt     (cnt_reg),
        .entry_digits  (entry_reg),
        .stored_cnt    (stored_cnt_reg),
        .stored_digits (stored_reg),
        .equal         (match_cur)
    );

    // data-path updates per mode
    always_comb
    begin
        att_next        = att_reg;
        cnt_next        = cnt_reg;
        entry_next      = entry_reg;
        stored_next     = stored_reg;
        stored_cnt_next = stored_cnt_reg;
        unique case (mode_reg)
            kpl_pkg::MODE_ENTRY:
            begin
                cnt_next = edit_cnt;
                if (edit_we)
                    entry_next[cnt_reg[IW-1:0]] = code;
                if (is_enter)
                begin
                    if (match_cur)
                        cnt_next = '0;
                    else if (att_reg != 4'd0)
                        att_next = att_reg - 4'd1;
                end
            end
            kpl_pkg::MODE_OPEN:
            begin
                cnt_next = '0;
            end
            kpl_pkg::MODE_NEWPW:
            begin
                cnt_next = edit_cnt;
                if (edit_we)
                    entry_next[cnt_reg[IW-1:0]] = code;
                if (save)
                begin
                    for (int i = 0; i < MAX_DIGITS; i++)
                    begin
                        if (CW'(i) < cnt_reg)
                            stored_next[i] = entry_reg[i];
                    end
                    stored_cnt_next = cnt_reg;
                    cnt_next        = '0;
                end
            end
            kpl_pkg::MODE_LOCKED:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // mode transitions
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            kpl_pkg::MODE_ENTRY:
            begin
                if (is_enter && match_cur)
                    mode_next = kpl_pkg::MODE_OPEN;
                else if (att_next == 4'd0)
                    mode_next = kpl_pkg::MODE_LOCKED;
            end
            kpl_pkg::MODE_OPEN:
            begin
                if (is_enter)
                    mode_next = kpl_pkg::MODE_NEWPW;
            end
            kpl_pkg::MODE_NEWPW:
            begin
                if (save)
                    mode_next = kpl_pkg::MODE_OPEN;
            end
            kpl_pkg::MODE_LOCKED:
            begin
                mode_next = kpl_pkg::MODE_LOCKED;
            end
        endcase
    end

    // compare after the update, for the result
    kpl_match #(.MAX_DIGITS(MAX_DIGITS)) u_match_next (
        .entry_cnt     (cnt_next),
        .entry_digits  (entry_next),
        .stored_cnt    (stored_cnt_next),
        .stored_digits (stored_next),
        .equal         (match_next)
    );

    // first digits packed, empty slots read as zero
    always_comb
    begin
        packed_digits = '0;
        for (int i = 0; i < PACK_N; i++)
        begin
            if (CW'(i) < cnt_next)
                packed_digits[4*i +: 4] = entry_next[i];
        end
    end

    assign res_next.mode          = mode_next;
    assign res_next.attempts_left = att_next;
    assign res_next.entry_length  = 4'(cnt_next);
    assign res_next.entry_digits  = packed_digits;
    assign res_next.entry_matches = match_next;

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= kpl_pkg::MODE_ENTRY;
            min_len_reg    <= kpl_pkg::MIN_NEW_LENGTH_RST;
            att_reg        <= kpl_pkg::MAX_ATTEMPTS_RST;
            cnt_reg        <= '0;
            stored_cnt_reg <= CW'(STORED_RST);
        end
        else
        begin
            if (cfg_we && (cfg_addr == kpl_pkg::CFG_MAX_ATTEMPTS))
                att_reg <= cfg_data;
            else if (advance)
                att_reg <= att_next;
            if (cfg_we && (cfg_addr == kpl_pkg::CFG_MIN_NEW_LENGTH))
                min_len_reg <= cfg_data;
            if (advance)
            begin
                mode_reg       <= mode_next;
                cnt_reg        <= cnt_next;
                stored_cnt_reg <= stored_cnt_next;
            end
        end
    end

    // stored password, reset to 1 2 3 4 5 6 7 8
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                stored_reg[i] <= (i < 8) ? 4'(i + 1) : 4'd0;
        end
        else if (advance)
            stored_reg <= stored_next;
    end

    // entry buffer, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
            entry_reg <= entry_next;
    end

endmodule

@@ rtl/kpl_out_stage.sv @@
// ----------------------------------------------------------------------------
// kpl_out_stage
// Result register on the master side; reloads while the old result is taken.
// ----------------------------------------------------------------------------
module kpl_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  kpl_pkg::result_t                  res_next,
    output logic                              load_ok,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [kpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic              valid_reg, valid_next;
    kpl_pkg::result_t  res_reg;

    assign load_ok = !valid_reg || m_axis_tready;

    always_comb
    begin
        if (advance)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(kpl_pkg::OUT_TDATA_W - $bits(kpl_pkg::result_t))'(0), res_reg};

endmodule

@@ rtl/keypad_password_lock_unit.sv @@
// ----------------------------------------------------------------------------
// keypad_password_lock_unit
// Keypad password lock: key presses in, lock status and entry out.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid / tready        | tdata[3:0] key_index
//  m_axis    | out       | tvalid / tready        | tdata[42:0] result fields
//  cfg       | in        | cfg_we, no wait        | cfg_addr index, cfg_data value
//
//  one key request per clock sustained while each result is taken as it is
//  shown; an accepted key passes the input register, then one pass of
//  decode, compare and update into the result register
//  reset sets mode, counts and control registers at once and loads the
//  default password; the entry buffer and payload registers have no reset;
//  there is no clearing pass
//  a stalled result holds while the next key waits in the input register
// ----------------------------------------------------------------------------
module keypad_password_lock_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [kpl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [3:0] key_index
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] mode, [5:2] attempts_left, [9:6] entry_length,
    // [41:10] entry_digits, [42] entry_matches
    output logic [kpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [kpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    kpl_pkg::key_req_t  req;
    kpl_pkg::result_t   res_next;
    logic               load_ok;
    logic               advance;

    // key moves on when the result register can take its result
    assign advance = req.valid && load_ok;

    kpl_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .req           (req)
    );

    kpl_core #(.MAX_DIGITS(MAX_DIGITS)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .req      (req),
        .advance  (advance),
        .res_next (res_next)
    );

    kpl_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .res_next      (res_next),
        .load_ok       (load_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/kpl_checker.sv @@
// ----------------------------------------------------------------------------
// kpl_checker
// Port-level checks on the password lock, bound to the top level.
// ----------------------------------------------------------------------------
module kpl_checker #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [kpl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic out_take;
    assign out_take = m_axis_tvalid && m_axis_tready;

    // a result request stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result request dropped before taken");

    // once locked, the next result is locked too
    a_lock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && (m_axis_tdata[1:0] == kpl_pkg::MODE_LOCKED))
        |=> (!m_axis_tvalid || (m_axis_tdata[1:0] == kpl_pkg::MODE_LOCKED)))
        else $error("lock released without reset");

    // no entry mode shown with zero attempts left
    a_zero_locks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !((m_axis_tdata[5:2] == 4'd0)
                            && (m_axis_tdata[1:0] == kpl_pkg::MODE_ENTRY)))
        else $error("entry mode with no attempts left");

    // entry length bounded by the buffer
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((MAX_DIGITS > 15) || (m_axis_tdata[9:6] <= 4'(MAX_DIGITS))))
        else $error("entry length beyond buffer");

    // empty entry shows no digits; a wide buffer wraps the length field
    a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[9:6] == 4'd0))
        |-> ((MAX_DIGITS > 15) || (m_axis_tdata[41:10] == 32'd0)))
        else $error("digits shown on empty entry");

endmodule

bind keypad_password_lock_unit kpl_checker #(.MAX_DIGITS(MAX_DIGITS)) u_kpl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
